FILE: src/msi_pkg.sv
// Package for the median selector: payload structs, register map and the
// float ordering key. Used by msi_cell and median_select_with_index.
package msi_pkg;

  localparam int unsigned PosW  = 10;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 2;

  localparam logic [AddrW-1:0] RegNanSkip = 2'd0;

  typedef struct packed {
    logic [DataW-1:0] sample_bits;
    logic             last_sample;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] median_bits;
    logic [PosW-1:0]  median_position;
    logic             overflowed;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] bits;
    logic [PosW-1:0]  pos;
  } cell_t;

  function automatic logic is_nan(input logic [DataW-1:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // Monotonic unsigned key for numbers; both zeros share one key.
  function automatic logic [DataW-1:0] order_key(input logic [DataW-1:0] b);
    logic [DataW-1:0] k;
    if (b[30:0] == 31'd0) begin
      k = 32'h8000_0000;
    end else if (b[31]) begin
      k = ~b;
    end else begin
      k = b | 32'h8000_0000;
    end
    return k;
  endfunction

endpackage

FILE: src/median_select_with_index.sv
// Top level of the lower-median selector with arrival index.
// Depends on msi_pkg and msi_cell.
//
// Samples arrive on the in channel (in_valid/in_ready/in_data), one transfer
// per cycle while a slice loads. Every kept non-NaN sample is inserted into a
// chain of MAX_SLICE cells that keeps them in ascending order.
// The transfer that carries last_sample closes the slice. The chain then
// shifts toward cell 0 once per cycle, (m-1)/2 times for m non-NaN samples,
// and cell 0 gives the result; a NaN result needs no shifting. The result
// is registered onto the out channel once the shifting is done and the out
// register is empty or being read, and in_ready is low until then. The out
// register holds the result until the receiver takes it; loading goes on
// meanwhile, but the next result waits for the out register to empty.
// Samples beyond MAX_SLICE are dropped and set overflowed. The NaN-skip
// register sits at APB address 0.
// Reset empties the chain and the slice counters and clears the NaN-skip mode.
module median_select_with_index #(
  parameter int unsigned MAX_SLICE = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  msi_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output msi_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msi_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import msi_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SLICE + 1);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t           state;
  logic [CntW-1:0]  sample_count;
  logic [CntW-1:0]  nan_count;
  logic [CntW-1:0]  drain_cnt;
  logic [PosW-1:0]  first_nan_pos;
  logic [DataW-1:0] first_nan_bits;
  logic             nan_seen;
  logic             overflow_seen;
  logic             nan_skip;
  logic             use_nan;

  cell_t            cq [MAX_SLICE];
  logic             gt [MAX_SLICE];

  logic             accept, kept, smp_nan, do_insert, do_drain, finish;
  logic [CntW-1:0]  m_next;
  logic             nan_seen_next;
  cell_t            new_cell;
  logic [31:0]      new_key;

  assign pready   = 1'b1;
  assign prdata   = (paddr == RegNanSkip) ? {31'd0, nan_skip} : 32'd0;
  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign kept     = sample_count < CntW'(MAX_SLICE);
  assign smp_nan  = is_nan(in_data.sample_bits);
  assign do_insert = accept && kept && !smp_nan;
  assign new_key  = order_key(in_data.sample_bits);
  assign new_cell = '{valid: 1'b1, bits: in_data.sample_bits, pos: PosW'(sample_count)};
  assign m_next   = sample_count - nan_count + CntW'(do_insert);
  assign nan_seen_next = nan_seen || (kept && smp_nan);
  assign finish   = (state == ST_DRAIN) && (use_nan || drain_cnt == '0)
                    && (!out_valid || out_ready);
  assign do_drain = (state == ST_DRAIN) && !use_nan && (drain_cnt != '0);

  for (genvar i = 0; i < MAX_SLICE; i++) begin : g_cell
    cell_t left, right;
    logic  left_gt;
    if (i == 0) begin : g_first
      assign left    = '{valid: 1'b1, bits: '0, pos: '0};
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left    = cq[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == MAX_SLICE - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cq[i+1];
    end
    msi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (finish),
      .insert   (do_insert),
      .drain    (do_drain),
      .new_key  (new_key),
      .new_cell (new_cell),
      .left     (left),
      .left_gt  (left_gt),
      .right    (right),
      .q        (cq[i]),
      .gt       (gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      sample_count  <= '0;
      nan_count     <= '0;
      drain_cnt     <= '0;
      first_nan_pos <= '0;
      first_nan_bits <= '0;
      nan_seen      <= 1'b0;
      overflow_seen <= 1'b0;
      nan_skip      <= 1'b0;
      use_nan       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == RegNanSkip) begin
        nan_skip <= pwdata[0];
      end
      if (out_valid && out_ready && !finish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (kept) begin
              sample_count <= sample_count + 1'b1;
              if (smp_nan) begin
                nan_count <= nan_count + 1'b1;
                if (!nan_seen) begin
                  nan_seen       <= 1'b1;
                  first_nan_pos  <= PosW'(sample_count);
                  first_nan_bits <= in_data.sample_bits;
                end
              end
            end else begin
              overflow_seen <= 1'b1;
            end
            if (in_data.last_sample) begin
              state     <= ST_DRAIN;
              use_nan   <= (!nan_skip && nan_seen_next) || (m_next == '0);
              drain_cnt <= (m_next - 1'b1) >> 1;
            end
          end
        end
        ST_DRAIN: begin
          if (do_drain) begin
            drain_cnt <= drain_cnt - 1'b1;
          end
          if (finish) begin
            out_valid <= 1'b1;
            out_data.median_bits     <= use_nan ? first_nan_bits : cq[0].bits;
            out_data.median_position <= use_nan ? first_nan_pos : cq[0].pos;
            out_data.overflowed      <= overflow_seen;
            sample_count  <= '0;
            nan_count     <= '0;
            first_nan_pos <= '0;
            first_nan_bits <= '0;
            nan_seen      <= 1'b0;
            overflow_seen <= 1'b0;
            state         <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    do_drain |=> drain_cnt == $past(drain_cnt) - 1'b1)
    else $error("Drain counter did not step down by one.");

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    nan_count <= sample_count)
    else $error("NaN count exceeds the kept sample count.");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && !use_nan) |-> cq[0].valid)
    else $error("Chain head is empty while a number result is pending.");

  a_slice_cleared: assert property (@(posedge clk) disable iff (rst)
    finish |=> (sample_count == '0 && !nan_seen && !cq[0].valid))
    else $error("Slice state not cleared after a result.");
`endif

endmodule

FILE: src/msi_cell.sv
// One cell of the insertion chain: holds one kept sample in sorted order.
// Depends on msi_pkg for cell_t and order_key.
module msi_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic                    insert,
  input  logic                    drain,
  input  logic [31:0]             new_key,
  input  msi_pkg::cell_t          new_cell,
  input  msi_pkg::cell_t          left,
  input  logic                    left_gt,
  input  msi_pkg::cell_t          right,
  output msi_pkg::cell_t          q,
  output logic                    gt
);
  import msi_pkg::*;

  logic take;

  assign gt   = q.valid && (order_key(q.bits) > new_key);
  assign take = gt || (!q.valid && left.valid);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      q.valid <= 1'b0;
    end else if (drain) begin
      q <= right;
    end else if (insert && take) begin
      q <= left_gt ? left : new_cell;
    end
  end

endmodule

FILE: tb/msi_checker.sv
`timescale 1ns / 1ps
// Checker for the median selector: watches the sample, result and register
// channels, predicts each slice median and compares it. Depends on msi_pkg.
module msi_checker #(
  parameter int unsigned MAX_SLICE = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  msi_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  msi_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [msi_pkg::AddrW-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);
  import msi_pkg::*;

  logic [31:0] ranked_bits [MAX_SLICE];
  logic [9:0]  ranked_pos [MAX_SLICE];
  int          kept;
  int          nans;
  logic [9:0]  nan_pos;
  logic [31:0] nan_bits;
  logic        nan_hit;
  logic        dropped;
  logic        skip_nan;
  out_item_t   medians_due [$];

  function automatic logic float_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 0);
  endfunction

  function automatic logic [31:0] sort_key(input logic [31:0] b);
    if (b[30:0] == 0) return 32'h8000_0000;
    if (b[31]) return ~b;
    return {1'b1, b[30:0]};
  endfunction

  task automatic take_sample(input logic [31:0] b, input logic last);
    int slot;
    int m;
    out_item_t res;
    if (kept < MAX_SLICE) begin
      if (float_is_nan(b)) begin
        if (!nan_hit) begin
          nan_hit = 1'b1;
          nan_pos = kept[9:0];
          nan_bits = b;
        end
        nans++;
      end else begin
        slot = kept - nans;
        while (slot > 0 && sort_key(ranked_bits[slot-1]) > sort_key(b)) begin
          ranked_bits[slot] = ranked_bits[slot-1];
          ranked_pos[slot] = ranked_pos[slot-1];
          slot--;
        end
        ranked_bits[slot] = b;
        ranked_pos[slot] = kept[9:0];
      end
      kept++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      m = kept - nans;
      if ((!skip_nan && nan_hit) || m == 0) begin
        res.median_bits = nan_bits;
        res.median_position = nan_pos;
      end else begin
        res.median_bits = ranked_bits[(m-1)/2];
        res.median_position = ranked_pos[(m-1)/2];
      end
      res.overflowed = dropped;
      medians_due.push_back(res);
      kept = 0;
      nans = 0;
      nan_pos = '0;
      nan_bits = '0;
      nan_hit = 1'b0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      kept = 0;
      nans = 0;
      nan_pos = '0;
      nan_bits = '0;
      nan_hit = 1'b0;
      dropped = 1'b0;
      skip_nan = 1'b0;
      medians_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegNanSkip) begin
        skip_nan = pwdata[0];
      end
      if (out_valid && out_ready) begin
        if (medians_due.size() == 0) begin
          $error("result transfer with no slice closed: bits %h pos %0d",
                 out_data.median_bits, out_data.median_position);
          mismatches++;
        end else begin
          want = medians_due.pop_front();
          if (out_data.median_bits !== want.median_bits) begin
            $error("median_bits expected %h actual %h", want.median_bits,
                   out_data.median_bits);
            mismatches++;
          end
          if (out_data.median_position !== want.median_position) begin
            $error("median_position expected %0d actual %0d", want.median_position,
                   out_data.median_position);
            mismatches++;
          end
          if (out_data.overflowed !== want.overflowed) begin
            $error("overflowed expected %0b actual %0b", want.overflowed,
                   out_data.overflowed);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        take_sample(in_data.sample_bits, in_data.last_sample);
      end
    end
    outstanding = medians_due.size();
  end

  initial begin
    mismatches = 0;
    outstanding = 0;
  end
endmodule

FILE: tb/median_select_with_index_tb.sv
`timescale 1ns / 1ps
// Testbench top for median_select_with_index: drives slices of binary32 samples
// and the NaN-skip register, and gives the verdict. Depends on msi_pkg and msi_checker.
module median_select_with_index_tb;
  import msi_pkg::*;

  localparam int unsigned SliceCap = 1024;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  logic              calm;
  logic [31:0]       tie_pool [4];

  median_select_with_index #(.MAX_SLICE(SliceCap)) DUT (.*);

  msi_checker #(.MAX_SLICE(SliceCap)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("median_select_with_index_tb failed");
    $finish;
  end

  task automatic push_sample(input logic [31:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_bits: b, last_sample: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_nan_skip(input logic v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SliceCap / 2 + 20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegNanSkip;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] draw_sample(input int nan_pct);
    logic [31:0] b;
    b = $urandom;
    if ($urandom_range(0, 99) < nan_pct) begin
      b[30:23] = 8'hFF;
      if (b[22:0] == 0) b[0] = 1'b1;
    end else begin
      case ($urandom_range(0, 7)) inside
        0: b = {b[31], 31'd0};
        1: b = {b[31], 8'hFF, 23'd0};
        2, 3: b = tie_pool[$urandom_range(0, 3)];
        4: b[30:23] = 8'h00;
        default: if (b[30:23] == 8'hFF) b[22:0] = 23'd0;
      endcase
    end
    return b;
  endfunction

  task automatic random_slice(input int len);
    int nan_pct;
    case ($urandom_range(0, 3))
      0: nan_pct = 0;
      1: nan_pct = 10;
      2: nan_pct = 50;
      default: nan_pct = 100;
    endcase
    for (int i = 0; i < len; i++) begin
      push_sample(draw_sample(nan_pct), i == len - 1);
    end
  endtask

  task automatic random_phase(input int budget);
    int len;
    while (budget > 0) begin
      len = $urandom_range(1, 16);
      if (len > budget) len = budget;
      random_slice(len);
      budget -= len;
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      int stall;
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    tie_pool = '{32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000, 32'h8000_0000};
    calm = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_nan_skip(1'b0);
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h0000_0000, 1'b1);
    push_sample(32'h3F80_0000, 1'b0);
    push_sample(32'h7FC0_0000, 1'b0);
    push_sample(32'h4000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    push_sample(32'h7F80_0000, 1'b0);
    push_sample(32'hFF80_0000, 1'b0);
    push_sample(32'h7F7F_FFFF, 1'b0);
    push_sample(32'h0000_0001, 1'b1);

    write_nan_skip(1'b1);
    push_sample(32'h3F80_0000, 1'b0);
    push_sample(32'h7FC0_0000, 1'b0);
    push_sample(32'h4000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    push_sample(32'hFF80_0001, 1'b0);
    push_sample(32'h7F80_0001, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h8000_0001, 1'b0);
    push_sample(32'hFF7F_FFFF, 1'b1);

    random_phase(120);
    write_nan_skip(1'b0);
    random_phase(100);
    calm = 1'b1;
    random_phase(40);
    calm = 1'b0;

    write_nan_skip(1'b1);
    for (int i = 0; i < SliceCap + 6; i++) begin
      push_sample(draw_sample(5), i == SliceCap + 5);
    end
    random_phase(60);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SliceCap / 2 + 20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("median_select_with_index_tb passed");
    end else begin
      $display("median_select_with_index_tb failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/msi_pkg.sv
src/msi_cell.sv
src/median_select_with_index.sv
tb/msi_checker.sv
tb/median_select_with_index_tb.sv
